[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define BIER_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BIER_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bier_pkg.sv]
// Shared types and constants of the bus interrupt and error status registers.
package bier_pkg;

  typedef enum logic [2:0] {
    FUNC_READ      = 3'd0,
    FUNC_WRITE     = 3'd1,
    FUNC_UNI_ON    = 3'd2,
    FUNC_UNI_OFF   = 3'd3,
    FUNC_XBUS_ON   = 3'd4,
    FUNC_XBUS_OFF  = 3'd5,
    FUNC_XBUS_NXM  = 3'd6,
    FUNC_MAP_ERR   = 3'd7
  } func_t;

  localparam int unsigned ADDR_W = 18;
  localparam int unsigned DATA_W = 16;

  // Error status bit positions.
  localparam int unsigned XBUS_NXM_BIT   = 0;
  localparam int unsigned UNIBUS_NXM_BIT = 1;
  localparam int unsigned UNIBUS_MAP_BIT = 2;

  localparam logic [DATA_W-1:0] ERR_XBUS_NXM   = DATA_W'(1) << XBUS_NXM_BIT;
  localparam logic [DATA_W-1:0] ERR_UNIBUS_NXM = DATA_W'(1) << UNIBUS_NXM_BIT;
  localparam logic [DATA_W-1:0] ERR_UNIBUS_MAP = DATA_W'(1) << UNIBUS_MAP_BIT;

  // Interrupt status fields.
  localparam logic [DATA_W-1:0] PEND_MASK  = 16'o140000;
  localparam logic [DATA_W-1:0] UNI_ENABLE = 16'o002000;
  localparam logic [DATA_W-1:0] VEC_MASK   = 16'o001774;
  localparam logic [DATA_W-1:0] UNI_INT    = 16'o100000;
  localparam logic [DATA_W-1:0] XBUS_INT   = 16'o040000;
  localparam logic [DATA_W-1:0] W0_MASK    = 16'o036001;
  localparam logic [DATA_W-1:0] W1_MASK    = 16'o101774;

  // Unibus addresses.
  localparam logic [ADDR_W-1:0] ADDR_INT    = 18'o766040;
  localparam logic [ADDR_W-1:0] ADDR_INT_HI = 18'o766042;
  localparam logic [ADDR_W-1:0] ADDR_ERR    = 18'o766044;
  localparam logic [ADDR_W-1:0] ADDR_DEV0   = 18'o766100;
  localparam logic [ADDR_W-1:0] ADDR_DEV1   = 18'o766102;
  localparam logic [ADDR_W-1:0] ADDR_DEV2   = 18'o766104;
  localparam logic [ADDR_W-1:0] ADDR_DEV3   = 18'o766110;
  localparam logic [ADDR_W-1:0] ADDR_DEV4   = 18'o766112;
  localparam logic [ADDR_W-1:0] ADDR_DEV5   = 18'o766114;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] vector;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              status;
    logic              irq_pending;
  } result_t;

endpackage

[hw/rtl/bier_in_stage.sv]
// Input register stage: holds one accepted word until the core takes it.
module bier_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bier_pkg::in_word_t in_word,
  input  logic              take,
  output logic              word_valid,
  output bier_pkg::in_word_t word
);

  logic               valid_r;
  logic               valid_nxt;
  bier_pkg::in_word_t word_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !take);
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

[hw/rtl/bier_core.sv]
// Status registers, operation decode and the result register.
module bier_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               word_valid,
  input  bier_pkg::in_word_t word,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output bier_pkg::result_t  result
);

  logic [bier_pkg::DATA_W-1:0] int_r, int_nxt;
  logic [bier_pkg::DATA_W-1:0] err_r, err_nxt;
  logic                        inhibit_r;
  logic                        out_valid_r;
  bier_pkg::result_t           result_r, result_nxt;
  logic [bier_pkg::DATA_W-1:0] nxm_bit;

  assign take = word_valid && (!out_valid_r || out_ready);

  always_comb begin
    int_nxt    = int_r;
    err_nxt    = err_r;
    result_nxt = '0;
    nxm_bit    = inhibit_r ? '0 : bier_pkg::ERR_UNIBUS_NXM;
    unique case (word.func)
      bier_pkg::FUNC_READ: begin
        unique case (word.address)
          bier_pkg::ADDR_INT: result_nxt.read_data = int_r;
          bier_pkg::ADDR_ERR: result_nxt.read_data = err_r;
          bier_pkg::ADDR_DEV0,
          bier_pkg::ADDR_DEV2: result_nxt.status = 1'b1;
          default: begin
            result_nxt.status = 1'b1;
            err_nxt = err_r | nxm_bit;
          end
        endcase
      end
      bier_pkg::FUNC_WRITE: begin
        unique case (word.address)
          bier_pkg::ADDR_INT:
            int_nxt = (int_r & ~bier_pkg::W0_MASK) | (word.write_data & bier_pkg::W0_MASK);
          bier_pkg::ADDR_INT_HI:
            int_nxt = (int_r & ~bier_pkg::W1_MASK) | (word.write_data & bier_pkg::W1_MASK);
          bier_pkg::ADDR_ERR: err_nxt = '0;
          bier_pkg::ADDR_DEV0,
          bier_pkg::ADDR_DEV1,
          bier_pkg::ADDR_DEV3,
          bier_pkg::ADDR_DEV4,
          bier_pkg::ADDR_DEV5: result_nxt.status = 1'b1;
          default: begin
            result_nxt.status = 1'b1;
            err_nxt = err_r | nxm_bit;
          end
        endcase
      end
      bier_pkg::FUNC_UNI_ON: begin
        if ((int_r & bier_pkg::UNI_ENABLE) != '0) begin
          int_nxt = (int_r & ~bier_pkg::VEC_MASK) | bier_pkg::UNI_INT
                    | (word.vector & bier_pkg::VEC_MASK);
        end
      end
      bier_pkg::FUNC_UNI_OFF: begin
        if ((int_r & bier_pkg::UNI_INT) != '0) begin
          int_nxt = int_r & ~(bier_pkg::VEC_MASK | bier_pkg::UNI_INT);
        end
      end
      bier_pkg::FUNC_XBUS_ON:  int_nxt = int_r | bier_pkg::XBUS_INT;
      bier_pkg::FUNC_XBUS_OFF: int_nxt = int_r & ~bier_pkg::XBUS_INT;
      bier_pkg::FUNC_XBUS_NXM: begin
        if (!inhibit_r) begin
          err_nxt = err_r | bier_pkg::ERR_XBUS_NXM;
        end
      end
      bier_pkg::FUNC_MAP_ERR:  err_nxt = err_r | bier_pkg::ERR_UNIBUS_MAP;
      default: ;
    endcase
    result_nxt.irq_pending = (int_nxt & bier_pkg::PEND_MASK) != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      err_r       <= '0;
      inhibit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        inhibit_r <= cfg_wr_data;
      end
      if (take) begin
        int_r       <= int_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

[hw/rtl/bus_interrupt_error_registers.sv]
// Bus interface interrupt status and error status registers. Each input word
// is one operation (register read or write, unibus or xbus interrupt assert
// or deassert, or an xbus nxm or map error event) and produces exactly one
// result word: read data, an ok/error status and the interrupt-pending flag
// taken after the operation's update. A word is held in the input register
// and is then decoded and applied in a single pass of logic into the result
// register, so the block sustains one word per cycle while out_ready is held
// high, and the result is valid once the word has passed both registers. The
// input register decouples the two sides: a new word is taken while a finished
// result still waits for out_ready, and back-pressure reaches in_ready only
// when both the input and result registers are full. The nxm inhibit bit is
// written through cfg_wr_en/cfg_wr_data and takes effect on the next word.
module bus_interrupt_error_registers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [17:0] in_address,
  input  logic [15:0] in_write_data,
  input  logic [15:0] in_vector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_status,
  output logic        out_irq_pending
);

  bier_pkg::in_word_t in_word;
  bier_pkg::in_word_t word;
  bier_pkg::result_t  result;
  logic               word_valid;
  logic               take;

  // Pack the input word; every func code is a defined operation.
  assign in_word.func       = bier_pkg::func_t'(in_func);
  assign in_word.address    = in_address;
  assign in_word.write_data = in_write_data;
  assign in_word.vector     = in_vector;

  // Hold the accepted word until the core can advance it.
  bier_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .take       (take),
    .word_valid (word_valid),
    .word       (word)
  );

  // Apply the operation to the status registers and load the result.
  bier_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word_valid  (word_valid),
    .word        (word),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  // Unpack the result word onto its ports.
  assign out_read_data   = result.read_data;
  assign out_status      = result.status;
  assign out_irq_pending = result.irq_pending;

endmodule

[hw/rtl/bier_checker.sv]
// Port-level checker for the bus interrupt and error status registers.
`include "assert_macros.svh"

module bier_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_read_data,
  input logic        out_status
);

  `BIER_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  `BIER_ASSERT(a_err_no_data, clk, rst_n, out_valid && out_status |-> out_read_data == 16'd0, "error result carries data")
  `BIER_ASSERT(a_stall_only_full, clk, rst_n, !in_ready |-> out_valid, "input stalled with result register empty")
  `BIER_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BIER_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_read_data), "result data changed while stalled")

endmodule

bind bus_interrupt_error_registers bier_checker u_bier_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data),
  .out_status    (out_status)
);

[tb/sv/tb_bus_interrupt_error_registers.sv]
// Self-checking testbench for the bus interrupt and error status registers.
module tb_bus_interrupt_error_registers;

  // Cycles with no handshake on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     cfg_wr_en = 1'b0;
  logic     cfg_wr_data = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bier_pkg::in_word_t drive_word = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  logic [15:0] out_read_data;
  logic     out_status;
  logic     out_irq_pending;

  // Words waiting to be sent, and results predicted for words already taken.
  bier_pkg::in_word_t pending_ops[$];
  bier_pkg::result_t  expected_results[$];

  // Shadow copy of the block's registers and its nxm inhibit setting.
  logic [15:0] model_int_status = '0;
  logic [15:0] model_err_status = '0;
  logic        model_nxm_inhibit = 1'b0;

  // One chance in idle_odds per cycle to start an idle burst; zero means none.
  int idle_odds = 0;
  int send_gap = 0;
  int sink_stall = 0;
  logic word_taken = 1'b0;
  int quiet_cycles = 0;
  int mismatches = 0;

  bus_interrupt_error_registers dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (drive_word.func),
    .in_address      (drive_word.address),
    .in_write_data   (drive_word.write_data),
    .in_vector       (drive_word.vector),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .out_irq_pending (out_irq_pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [15:0] rand_data();
    return 16'($urandom);
  endfunction

  function automatic logic [17:0] rand_addr();
    return 18'($urandom);
  endfunction

  // Apply one word to the shadow registers and return the result it should give.
  function automatic bier_pkg::result_t apply_bus_op(input bier_pkg::in_word_t w);
    bier_pkg::result_t r;
    r = '0;
    case (w.func)
      bier_pkg::FUNC_READ: begin
        r.status = 1'b1;
        case (w.address)
          bier_pkg::ADDR_INT: begin
            r.read_data = model_int_status;
            r.status = 1'b0;
          end
          bier_pkg::ADDR_ERR: begin
            r.read_data = model_err_status;
            r.status = 1'b0;
          end
          // Known devices that are not built answer an error but log nothing.
          bier_pkg::ADDR_DEV0, bier_pkg::ADDR_DEV2: ;
          default: begin
            if (!model_nxm_inhibit)
              model_err_status = model_err_status | bier_pkg::ERR_UNIBUS_NXM;
          end
        endcase
      end
      bier_pkg::FUNC_WRITE: begin
        case (w.address)
          bier_pkg::ADDR_INT:
            model_int_status = (model_int_status & ~bier_pkg::W0_MASK) |
                               (w.write_data & bier_pkg::W0_MASK);
          bier_pkg::ADDR_INT_HI:
            model_int_status = (model_int_status & ~bier_pkg::W1_MASK) |
                               (w.write_data & bier_pkg::W1_MASK);
          bier_pkg::ADDR_ERR: model_err_status = '0;
          bier_pkg::ADDR_DEV0, bier_pkg::ADDR_DEV1, bier_pkg::ADDR_DEV3,
          bier_pkg::ADDR_DEV4, bier_pkg::ADDR_DEV5: r.status = 1'b1;
          default: begin
            r.status = 1'b1;
            if (!model_nxm_inhibit)
              model_err_status = model_err_status | bier_pkg::ERR_UNIBUS_NXM;
          end
        endcase
      end
      bier_pkg::FUNC_UNI_ON: begin
        // Latch the vector only while the unibus enable bit is set.
        if ((model_int_status & bier_pkg::UNI_ENABLE) != '0)
          model_int_status = (model_int_status & ~bier_pkg::VEC_MASK) | bier_pkg::UNI_INT |
                             (w.vector & bier_pkg::VEC_MASK);
      end
      bier_pkg::FUNC_UNI_OFF: begin
        if ((model_int_status & bier_pkg::UNI_INT) != '0)
          model_int_status = model_int_status & ~(bier_pkg::VEC_MASK | bier_pkg::UNI_INT);
      end
      bier_pkg::FUNC_XBUS_ON: model_int_status = model_int_status | bier_pkg::XBUS_INT;
      bier_pkg::FUNC_XBUS_OFF: model_int_status = model_int_status & ~bier_pkg::XBUS_INT;
      bier_pkg::FUNC_XBUS_NXM: begin
        if (!model_nxm_inhibit)
          model_err_status = model_err_status | bier_pkg::ERR_XBUS_NXM;
      end
      default: model_err_status = model_err_status | bier_pkg::ERR_UNIBUS_MAP;
    endcase
    r.irq_pending = (model_int_status & bier_pkg::PEND_MASK) != '0;
    return r;
  endfunction

  // Driver: move to the next word once the current one is taken, with idle bursts.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        send_gap <= $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        drive_word <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: hold out_ready low in random stall bursts.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      sink_stall <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check results first, then predict for the word taken at this edge,
  // so a result never meets an expectation pushed in the same cycle.
  always @(posedge clk) begin
    bier_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got read_data %h status %b pending %b",
                   $time, out_read_data, out_status, out_irq_pending);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $display("%0t: read_data expected %h, got %h", $time, want.read_data,
                     out_read_data);
            mismatches = mismatches + 1;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %b, got %b", $time, want.status, out_status);
            mismatches = mismatches + 1;
          end
          if (out_irq_pending !== want.irq_pending) begin
            $display("%0t: irq_pending expected %b, got %b", $time,
                     want.irq_pending, out_irq_pending);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_bus_op(drive_word));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
    word_taken <= in_valid && in_ready;
  end

  task automatic push_op(input bier_pkg::func_t f, input logic [17:0] a,
                         input logic [15:0] d, input logic [15:0] v);
    bier_pkg::in_word_t w;
    w.func = f;
    w.address = a;
    w.write_data = d;
    w.vector = v;
    pending_ops.push_back(w);
  endtask

  // Hold until every queued word is sent and every result has come back.
  task automatic wait_until_drained();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_nxm_inhibit(input logic v);
    wait_until_drained();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_nxm_inhibit = v;
  endtask

  // Mostly register traffic to decoded addresses, plus near misses and noise.
  task automatic queue_random_ops(input int count);
    bier_pkg::in_word_t w;
    int i;
    int pick;
    for (i = 0; i < count; i++) begin
      w.address = rand_addr();
      w.write_data = rand_data();
      w.vector = rand_data();
      pick = $urandom_range(0, 15);
      if (pick < 4)
        w.func = bier_pkg::FUNC_READ;
      else if (pick < 9)
        w.func = bier_pkg::FUNC_WRITE;
      else
        w.func = bier_pkg::func_t'($urandom_range(2, 7));
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        case ($urandom_range(0, 8))
          0: w.address = bier_pkg::ADDR_INT;
          1: w.address = bier_pkg::ADDR_INT_HI;
          2: w.address = bier_pkg::ADDR_ERR;
          3: w.address = bier_pkg::ADDR_DEV0;
          4: w.address = bier_pkg::ADDR_DEV1;
          5: w.address = bier_pkg::ADDR_DEV2;
          6: w.address = bier_pkg::ADDR_DEV3;
          7: w.address = bier_pkg::ADDR_DEV4;
          default: w.address = bier_pkg::ADDR_DEV5;
        endcase
        // Flip one address bit now and then to land next to a register.
        if (pick == 7)
          w.address = w.address ^ (18'd1 << $urandom_range(0, 17));
      end
      pending_ops.push_back(w);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass with nxm errors recorded.
    idle_odds = 4;
    set_nxm_inhibit(1'b0);
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_INT, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_INT, 16'hFFFF, rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_INT_HI, 16'hFFFF, rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_INT, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_UNI_OFF, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_UNI_OFF, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_UNI_ON, rand_addr(), rand_data(), 16'hFFFF);
    push_op(bier_pkg::FUNC_UNI_ON, rand_addr(), rand_data(), 16'h0000);
    push_op(bier_pkg::FUNC_XBUS_ON, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_INT, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_XBUS_OFF, rand_addr(), rand_data(), rand_data());
    // Drop the enable with the unibus interrupt still up, then try to re-latch.
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_INT, 16'h0000, rand_data());
    push_op(bier_pkg::FUNC_UNI_ON, rand_addr(), rand_data(), 16'hFFFF);
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_INT, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_XBUS_NXM, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_MAP_ERR, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_DEV0, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_DEV2, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV0, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV1, rand_data(), rand_data());
    // The third device address only answers reads; a write there is nonexistent.
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV2, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV3, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV4, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_DEV5, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, 18'h00000, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, 18'h3FFFF, rand_data(), rand_data());
    // The high interrupt address only decodes for writes.
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_INT_HI, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_ERR, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_WRITE, bier_pkg::ADDR_ERR, rand_data(), rand_data());

    // Directed pass with nxm errors suppressed.
    set_nxm_inhibit(1'b1);
    push_op(bier_pkg::FUNC_READ, 18'h3FFFF, rand_data(), rand_data());
    push_op(bier_pkg::FUNC_XBUS_NXM, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_MAP_ERR, rand_addr(), rand_data(), rand_data());
    push_op(bier_pkg::FUNC_READ, bier_pkg::ADDR_ERR, rand_data(), rand_data());

    // Random phases; the last one runs with no idling on either side.
    idle_odds = 3;
    set_nxm_inhibit(1'b0);
    queue_random_ops(260);
    idle_odds = 0;
    set_nxm_inhibit(1'b1);
    queue_random_ops(260);
    idle_odds = 8;
    set_nxm_inhibit(1'($urandom_range(0, 1)));
    queue_random_ops(260);
    idle_odds = 0;
    set_nxm_inhibit(1'b0);
    queue_random_ops(260);

    wait_until_drained();
    // Keep clocking so that any stray result still shows up.
    repeat (6) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
